### src/synapse_row_table_core_macros.svh
// Assertion macros for the synapse row table core.
// Used by the top level only; the macros refer to its clk and rst_n.
`ifndef SYNAPSE_ROW_TABLE_CORE_MACROS_SVH
`define SYNAPSE_ROW_TABLE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define SRT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("synapse row table: assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define SRT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("synapse row table: assertion failed");
`else
`define SRT_ASSERT_NOW(label, ante, cons)
`define SRT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### src/srt_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// synapse row table. No dependencies.
`default_nettype none

package srt_pkg;

    localparam int ROW_DEPTH   = 256;
    localparam int WEIGHT_BITS = 16;
    localparam int WORD_W      = 32;
    localparam int ROW_AW      = $clog2(ROW_DEPTH);
    localparam int CNT_W       = $clog2(ROW_DEPTH + 1);

    // Field widths of the transaction payloads
    localparam int OP_W     = 2;
    localparam int ID_W     = 14;
    localparam int WT_W     = 16;
    localparam int DLY_W    = 8;
    localparam int TYP_W    = 4;
    localparam int OFF_W    = 8;
    localparam int STATUS_W = 2;
    localparam int ROWCNT_W = 9;

    // Configuration field widths
    localparam int IB_W = 4;
    localparam int TB_W = 3;
    localparam int DB_W = 4;
    localparam int SH_W = 5;

    localparam logic [OP_W-1:0] OP_FIND   = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ROW_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_OFFSET = 2'd3;

    // Effective (saturated) field widths
    typedef struct packed {
        logic [IB_W-1:0] ib;
        logic [TB_W-1:0] tb;
        logic [DB_W-1:0] db;
    } cfg_t;

    typedef struct packed {
        logic                load;
        logic                issue_scan;
        logic                write_add;
        logic                read_last;
        logic                write_move;
        logic                set_status;
        logic [STATUS_W-1:0] status_code;
        logic                capture_hit;
        logic                push_out;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic             row_full;
        logic             offset_bad;
        logic             scan_hit;
        logic             scan_done;
        logic             out_free;
        logic [CNT_W-1:0] count;
    } stat_t;

    function automatic logic [WORD_W-1:0] low_mask(input logic [SH_W-1:0] bits);
        return (WORD_W'(1) << bits) - WORD_W'(1);
    endfunction

endpackage

`default_nettype wire

### src/synapse_row_table_core.sv
// Synapse row table top level: APB configuration registers, controller and
// datapath. Depends on srt_pkg, srt_ctrl, srt_datapath and the macros header.
//
// Usage: an input transaction (op, id, weight, delay, syn_type, remove_offset)
// is taken when in_valid is high and in_stall low; each one yields exactly one
// result transaction (status, found_offset, out_weight, out_delay, out_type,
// row_count), taken when out_valid is high and out_stall low.
// One item is worked at a time. After decode, find scans the row RAM, one
// word per cycle on its read port, and a remove with a good offset reads the
// last word and writes it into the removed slot; add appends its packed word.
// The result appears in an output register; the next item is taken while it
// waits. If the receiver stalls, the result holds and a second finished
// result waits inside until the output register frees.
// Reset empties the row (count 0; words are undefined until written) and sets
// index_bits 8, type_bits 1, delay_bits 4. Registers lie at byte addresses
// 0, 4 and 8 and must be written only while the block is idle; the block
// itself does not enforce it.
`default_nettype none
`include "synapse_row_table_core_macros.svh"

module synapse_row_table_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [3:0]                      paddr,
    input  wire logic [31:0]                     pwdata,
    output logic      [31:0]                     prdata,
    output logic                                 pready,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [srt_pkg::OP_W-1:0]        op,
    input  wire logic [srt_pkg::ID_W-1:0]        id,
    input  wire logic [srt_pkg::WT_W-1:0]        weight,
    input  wire logic [srt_pkg::DLY_W-1:0]       delay,
    input  wire logic [srt_pkg::TYP_W-1:0]       syn_type,
    input  wire logic [srt_pkg::OFF_W-1:0]       remove_offset,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic      [srt_pkg::STATUS_W-1:0]    status,
    output logic      [srt_pkg::OFF_W-1:0]       found_offset,
    output logic      [srt_pkg::WT_W-1:0]        out_weight,
    output logic      [srt_pkg::DLY_W-1:0]       out_delay,
    output logic      [srt_pkg::TYP_W-1:0]       out_type,
    output logic      [srt_pkg::ROWCNT_W-1:0]    row_count
);

    import srt_pkg::*;

    localparam logic [1:0] REG_INDEX_BITS = 2'd0;
    localparam logic [1:0] REG_TYPE_BITS  = 2'd1;
    localparam logic [1:0] REG_DELAY_BITS = 2'd2;

    localparam logic [IB_W-1:0] IB_MAX = IB_W'(14);
    localparam logic [TB_W-1:0] TB_MAX = TB_W'(4);
    localparam logic [DB_W-1:0] DB_MAX = DB_W'(8);

    logic [IB_W-1:0] idx_bits_reg;
    logic [TB_W-1:0] typ_bits_reg;
    logic [DB_W-1:0] dly_bits_reg;
    logic            cfg_wr;

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_bits_reg <= IB_W'(8);
            typ_bits_reg <= TB_W'(1);
            dly_bits_reg <= DB_W'(4);
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_INDEX_BITS: idx_bits_reg <= pwdata[IB_W-1:0];
                REG_TYPE_BITS:  typ_bits_reg <= pwdata[TB_W-1:0];
                REG_DELAY_BITS: dly_bits_reg <= pwdata[DB_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_INDEX_BITS: prdata = 32'(idx_bits_reg);
            REG_TYPE_BITS:  prdata = 32'(typ_bits_reg);
            REG_DELAY_BITS: prdata = 32'(dly_bits_reg);
            default:        prdata = '0;
        endcase
    end

    // Saturate out-of-range widths; zero stays an empty field
    always_comb
    begin
        cfg.ib = (idx_bits_reg > IB_MAX) ? IB_MAX : idx_bits_reg;
        cfg.tb = (typ_bits_reg > TB_MAX) ? TB_MAX : typ_bits_reg;
        cfg.db = (dly_bits_reg > DB_MAX) ? DB_MAX : dly_bits_reg;
    end

    srt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    srt_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd           (cmd),
        .stat          (stat),
        .op            (op),
        .id            (id),
        .weight        (weight),
        .delay         (delay),
        .syn_type      (syn_type),
        .remove_offset (remove_offset),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .found_offset  (found_offset),
        .out_weight    (out_weight),
        .out_delay     (out_delay),
        .out_type      (out_type),
        .row_count     (row_count)
    );

    `SRT_ASSERT_NOW(a_count_bound, 1'b1, stat.count <= CNT_W'(ROW_DEPTH))
    `SRT_ASSERT_NOW(a_push_when_free, cmd.push_out, !out_valid || !out_stall)
    `SRT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    `SRT_ASSERT_NEXT(a_add_grows_row, cmd.write_add, stat.count == $past(stat.count) + CNT_W'(1))

endmodule

`default_nettype wire

### src/srt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module srt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### src/srt_ctrl.sv
// Controller state machine for the synapse row table.
// Depends on srt_pkg; drives srt_datapath through cmd_t and reads stat_t.
`default_nettype none

module srt_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire srt_pkg::stat_t  stat,
    output srt_pkg::cmd_t        cmd
);

    import srt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_SCAN   = 5'b00100,
        S_MOVE   = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.op)
                    OP_FIND:
                    begin
                        state_next = S_SCAN;
                    end
                    OP_ADD:
                    begin
                        if (stat.row_full)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_ROW_FULL;
                        end
                        else
                        begin
                            cmd.write_add = 1'b1;
                        end
                        state_next = S_FINISH;
                    end
                    OP_REMOVE:
                    begin
                        if (stat.offset_bad)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_BAD_OFFSET;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            // fetch the last word; it lands in the RAM output next cycle
                            cmd.read_last = 1'b1;
                            state_next    = S_MOVE;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.issue_scan = 1'b1;
                if (stat.scan_hit)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_OK;
                    cmd.capture_hit = 1'b1;
                    state_next      = S_FINISH;
                end
                else if (stat.scan_done)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_NOT_FOUND;
                    state_next      = S_FINISH;
                end
            end
            S_MOVE:
            begin
                cmd.write_move = 1'b1;
                state_next     = S_FINISH;
            end
            S_FINISH:
            begin
                // hold the result until the output register is free
                if (stat.out_free)
                begin
                    cmd.push_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/srt_datapath.sv
// Datapath of the synapse row table: item registers, word count, row RAM,
// scan pipeline, word packing/unpacking and the output register.
// Depends on srt_pkg and srt_ram.
`default_nettype none

module srt_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire srt_pkg::cfg_t                   cfg,
    input  wire srt_pkg::cmd_t                   cmd,
    output srt_pkg::stat_t                       stat,
    input  wire logic [srt_pkg::OP_W-1:0]        op,
    input  wire logic [srt_pkg::ID_W-1:0]        id,
    input  wire logic [srt_pkg::WT_W-1:0]        weight,
    input  wire logic [srt_pkg::DLY_W-1:0]       delay,
    input  wire logic [srt_pkg::TYP_W-1:0]       syn_type,
    input  wire logic [srt_pkg::OFF_W-1:0]       remove_offset,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic      [srt_pkg::STATUS_W-1:0]    status,
    output logic      [srt_pkg::OFF_W-1:0]       found_offset,
    output logic      [srt_pkg::WT_W-1:0]        out_weight,
    output logic      [srt_pkg::DLY_W-1:0]       out_delay,
    output logic      [srt_pkg::TYP_W-1:0]       out_type,
    output logic      [srt_pkg::ROWCNT_W-1:0]    row_count
);

    import srt_pkg::*;

    // Item registers
    logic [OP_W-1:0]  op_reg;
    logic [ID_W-1:0]  id_reg;
    logic [WT_W-1:0]  wt_reg;
    logic [DLY_W-1:0] dly_reg;
    logic [TYP_W-1:0] typ_reg;
    logic [OFF_W-1:0] off_reg;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  issue_idx_reg;
    logic              chk_valid_reg;
    logic [ROW_AW-1:0] chk_idx_reg;

    // Result held until the output register takes it
    logic [STATUS_W-1:0] res_status_reg;
    logic [OFF_W-1:0]    res_off_reg;
    logic [WT_W-1:0]     res_wt_reg;
    logic [DLY_W-1:0]    res_dly_reg;
    logic [TYP_W-1:0]    res_typ_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [OFF_W-1:0]    out_off_reg;
    logic [WT_W-1:0]     out_wt_reg;
    logic [DLY_W-1:0]    out_dly_reg;
    logic [TYP_W-1:0]    out_typ_reg;
    logic [CNT_W-1:0]    out_cnt_reg;

    logic              ram_we;
    logic [ROW_AW-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ROW_AW-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic [SH_W-1:0]   sh_dly;
    logic [WORD_W-1:0] pack_word;
    logic [CNT_W-1:0]  last_idx;
    logic              scan_more;
    logic              match;
    logic              scan_hit;
    logic              scan_rd;
    logic [WT_W-1:0]   hit_wt;
    logic [DLY_W-1:0]  hit_dly;
    logic [TYP_W-1:0]  hit_typ;

    assign sh_dly = SH_W'(cfg.ib) + SH_W'(cfg.tb);

    // Fields are ORed as they stand; wide settings may overlap the weight
    assign pack_word =
        {wt_reg[WEIGHT_BITS-1:0], {(WORD_W-WEIGHT_BITS){1'b0}}}
        | ((WORD_W'(dly_reg) & low_mask(SH_W'(cfg.db))) << sh_dly)
        | ((WORD_W'(typ_reg) & low_mask(SH_W'(cfg.tb))) << cfg.ib)
        | (WORD_W'(id_reg) & low_mask(SH_W'(cfg.ib)));

    assign last_idx  = count_reg - CNT_W'(1);
    assign scan_more = (issue_idx_reg < count_reg);
    // Full input id against the masked stored id: an over-wide id never matches
    assign match     = ((ram_rdata & low_mask(SH_W'(cfg.ib))) == WORD_W'(id_reg));
    assign scan_hit  = chk_valid_reg && match;
    assign scan_rd   = cmd.issue_scan && scan_more && !scan_hit;

    assign hit_wt  = WT_W'(ram_rdata[WORD_W-1 -: WEIGHT_BITS]);
    assign hit_dly = DLY_W'((ram_rdata >> sh_dly) & low_mask(SH_W'(cfg.db)));
    assign hit_typ = TYP_W'((ram_rdata >> cfg.ib) & low_mask(SH_W'(cfg.tb)));

    assign ram_re    = scan_rd || cmd.read_last;
    assign ram_raddr = cmd.read_last ? last_idx[ROW_AW-1:0] : issue_idx_reg[ROW_AW-1:0];
    assign ram_we    = cmd.write_add || cmd.write_move;
    assign ram_waddr = cmd.write_add ? count_reg[ROW_AW-1:0] : ROW_AW'(off_reg);
    assign ram_wdata = cmd.write_add ? pack_word : ram_rdata;

    srt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROW_DEPTH)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            issue_idx_reg <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.write_add)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.write_move)
            begin
                count_reg <= last_idx;
            end

            if (cmd.load)
            begin
                issue_idx_reg <= '0;
            end
            else if (scan_rd)
            begin
                issue_idx_reg <= issue_idx_reg + CNT_W'(1);
            end

            chk_valid_reg <= scan_rd;

            if (cmd.push_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op;
            id_reg  <= id;
            wt_reg  <= weight;
            dly_reg <= delay;
            typ_reg <= syn_type;
            off_reg <= remove_offset;
        end

        if (scan_rd)
        begin
            chk_idx_reg <= issue_idx_reg[ROW_AW-1:0];
        end

        if (cmd.load)
        begin
            res_status_reg <= ST_OK;
            res_off_reg    <= '0;
            res_wt_reg     <= '0;
            res_dly_reg    <= '0;
            res_typ_reg    <= '0;
        end
        else
        begin
            if (cmd.set_status)
            begin
                res_status_reg <= cmd.status_code;
            end
            if (cmd.capture_hit)
            begin
                res_off_reg <= OFF_W'(chk_idx_reg);
                res_wt_reg  <= hit_wt;
                res_dly_reg <= hit_dly;
                res_typ_reg <= hit_typ;
            end
        end

        if (cmd.push_out)
        begin
            out_status_reg <= res_status_reg;
            out_off_reg    <= res_off_reg;
            out_wt_reg     <= res_wt_reg;
            out_dly_reg    <= res_dly_reg;
            out_typ_reg    <= res_typ_reg;
            out_cnt_reg    <= count_reg;
        end
    end

    always_comb
    begin
        stat            = '0;
        stat.op         = op_reg;
        stat.row_full   = (count_reg >= CNT_W'(ROW_DEPTH));
        stat.offset_bad = ({{CNT_W{1'b0}}, off_reg} >= {{OFF_W{1'b0}}, count_reg});
        stat.scan_hit   = scan_hit;
        stat.scan_done  = !scan_more && !chk_valid_reg;
        stat.out_free   = !out_valid_reg || !out_stall;
        stat.count      = count_reg;
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign found_offset = out_off_reg;
    assign out_weight   = out_wt_reg;
    assign out_delay    = out_dly_reg;
    assign out_type     = out_typ_reg;
    assign row_count    = ROWCNT_W'(out_cnt_reg);

endmodule

`default_nettype wire
